>>> hw/rtl/mbps_pkg.sv
// ----------------------------------------------------------------------------
// mbps_pkg: shared types and constants for the masked byte pattern scanner
// Register indexes, widths, result type and pattern byte selection.
// ----------------------------------------------------------------------------
package mbps_pkg;

  localparam int MAX_PATTERN = 16;                     // window cells
  localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
  localparam int PAT_BYTES   = 16;                     // bytes held by the pattern registers
  localparam int SEEN_W      = 33;
  localparam int ADDR_W      = 32;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_IDX_W   = 3;
  localparam int PLEN_W      = 5;
  localparam int MASK_W      = 16;

  localparam logic [SEEN_W-1:0] SEEN_MAX = {SEEN_W{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BASE_ADDRESS   = 3'd0,
    REG_SCAN_LENGTH    = 3'd1,
    REG_PATTERN_LENGTH = 3'd2,
    REG_PATTERN_LOW    = 3'd3,
    REG_PATTERN_HIGH   = 3'd4,
    REG_CARE_MASK      = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic              found;
    logic [ADDR_W-1:0] match_address;
  } scan_result_t;

  // pattern byte k; bytes beyond the pattern registers read as zero
  function automatic logic [7:0] pattern_byte(input logic [8*PAT_BYTES-1:0] pat,
                                              input logic [LEN_W-1:0] k);
    logic [7:0] b;
    b = 8'd0;
    for (int i = 0; i < PAT_BYTES; i++) begin
      if ((i < MAX_PATTERN) && (k == LEN_W'(i))) b = pat[i*8 +: 8];
    end
    return b;
  endfunction

  // care bit k; bytes beyond the mask are wildcards
  function automatic logic care_bit(input logic [MASK_W-1:0] mask,
                                    input logic [LEN_W-1:0] k);
    logic c;
    c = 1'b0;
    for (int i = 0; i < MASK_W; i++) begin
      if ((i < MAX_PATTERN) && (k == LEN_W'(i))) c = mask[i];
    end
    return c;
  endfunction

endpackage

>>> hw/rtl/mbps_cell.sv
// ----------------------------------------------------------------------------
// mbps_cell: one byte of the sliding window
// Holds a byte, hands it to the next cell on each load, and compares the
// byte it is about to hold against its pattern byte.
// ----------------------------------------------------------------------------
module mbps_cell
  import mbps_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       load,
  input  logic       clear,     // start of scan: older cells go to zero
  input  logic [7:0] shift_in,
  input  logic [7:0] pat_byte,
  input  logic       care,
  input  logic       active,    // cell lies inside the pattern length
  output logic [7:0] byte_q,
  output logic       mismatch
);

  logic [7:0] byte_r;
  logic [7:0] byte_nxt;

  assign byte_nxt = clear ? 8'd0 : shift_in;
  assign mismatch = active && care && (byte_nxt != pat_byte);
  assign byte_q   = byte_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_r <= 8'd0;
    end else if (load) begin
      byte_r <= byte_nxt;
    end
  end

endmodule

>>> hw/rtl/mbps_out_buf.sv
// ----------------------------------------------------------------------------
// mbps_out_buf: result output register with skid stage
// Holds up to two results so the input side keeps flowing while the
// receiver stalls, until both are held.
// ----------------------------------------------------------------------------
module mbps_out_buf
  import mbps_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         res_valid,
  input  scan_result_t res,
  input  logic         out_stall,
  output logic         out_valid,
  output scan_result_t out_res,
  output logic         full
);

  logic         out_valid_r, out_valid_nxt;
  logic         skid_valid_r, skid_valid_nxt;
  scan_result_t out_res_r, out_res_nxt;
  scan_result_t skid_res_r, skid_res_nxt;
  logic         out_fire;

  assign out_fire  = out_valid_r && !out_stall;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;
  assign full      = skid_valid_r;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_res_nxt    = out_res_r;
    skid_valid_nxt = skid_valid_r;
    skid_res_nxt   = skid_res_r;
    if (skid_valid_r) begin
      // input is held off, so no new result arrives here
      if (out_fire || !out_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_res_nxt    = skid_res_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (res_valid) begin
      if (out_fire || !out_valid_r) begin
        out_valid_nxt = 1'b1;
        out_res_nxt   = res;
      end else begin
        skid_valid_nxt = 1'b1;
        skid_res_nxt   = res;
      end
    end else if (out_fire) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r  <= out_res_nxt;
    skid_res_r <= skid_res_nxt;
  end

endmodule

>>> hw/rtl/masked_byte_pattern_scanner.sv
// ----------------------------------------------------------------------------
// masked_byte_pattern_scanner: masked byte signature search over a stream
// Result: registered in the output buffer from the byte that decides it.
// Throughput: one byte per cycle unless the output buffer is full; the window
// is a chain of byte cells comparing in parallel in the cycle a byte enters.
// Reset: registers take their reset values, the window clears, and the
// scanner stays idle until a transaction with start_of_scan set.
// ----------------------------------------------------------------------------
module masked_byte_pattern_scanner
  import mbps_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // input channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            in_data_byte,
  input  logic                  in_start_of_scan,
  // result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_found,
  output logic [ADDR_W-1:0]     out_match_address,
  // configuration
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [ADDR_W-1:0]      base_address_r;
  logic [ADDR_W-1:0]      scan_length_r;
  logic [PLEN_W-1:0]      pattern_length_r;
  logic [8*PAT_BYTES-1:0] pattern_r;
  logic [MASK_W-1:0]      care_mask_r;

  logic [SEEN_W-1:0] seen_r, seen_nxt;
  logic              done_r, done_nxt;

  logic              accept;
  logic              live;
  logic [SEEN_W-1:0] seen_base;
  logic [LEN_W-1:0]  len_u;
  logic [SEEN_W-1:0] pos;
  logic [SEEN_W:0]   pos_p1;
  logic              enough;
  logic              past_end;
  logic              last_pos;
  logic              match;
  logic              res_valid;
  scan_result_t      res;
  scan_result_t      out_res;
  logic              buf_full;

  logic [7:0]             cell_q   [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] mismatch;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_address_r   <= '0;
      scan_length_r    <= '0;
      pattern_length_r <= PLEN_W'(1);
      pattern_r        <= '0;
      care_mask_r      <= '1;
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_index))
        REG_BASE_ADDRESS:   base_address_r   <= cfg_data[ADDR_W-1:0];
        REG_SCAN_LENGTH:    scan_length_r    <= cfg_data[ADDR_W-1:0];
        REG_PATTERN_LENGTH: pattern_length_r <= cfg_data[PLEN_W-1:0];
        REG_PATTERN_LOW:    pattern_r[CFG_DATA_W-1:0] <= cfg_data;
        REG_PATTERN_HIGH:   pattern_r[2*CFG_DATA_W-1:CFG_DATA_W] <= cfg_data;
        REG_CARE_MASK:      care_mask_r      <= cfg_data[MASK_W-1:0];
        default: ;
      endcase
    end
  end

  assign accept   = in_valid && !in_stall;
  assign in_stall = buf_full;
  assign live     = accept && (in_start_of_scan || !done_r);

  // pattern length in use, clamped to 1..MAX_PATTERN
  always_comb begin
    if (pattern_length_r == '0) begin
      len_u = LEN_W'(1);
    end else if (32'(pattern_length_r) > MAX_PATTERN) begin
      len_u = LEN_W'(MAX_PATTERN);
    end else begin
      len_u = LEN_W'(pattern_length_r);
    end
  end

  // window cells, newest byte in cell 0
  for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
    localparam logic [LEN_W-1:0] J = LEN_W'(j);
    logic [LEN_W-1:0] k;
    logic [7:0]       shift_in;
    logic             clear;

    assign k = len_u - LEN_W'(1) - J;   // pattern byte facing this cell
    if (j == 0) begin : g_head
      assign shift_in = in_data_byte;
      assign clear    = 1'b0;
    end else begin : g_body
      assign shift_in = cell_q[j-1];
      assign clear    = in_start_of_scan;
    end

    mbps_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .load     (live),
      .clear    (clear),
      .shift_in (shift_in),
      .pat_byte (pattern_byte(pattern_r, k)),
      .care     (care_bit(care_mask_r, k)),
      .active   (J < len_u),
      .byte_q   (cell_q[j]),
      .mismatch (mismatch[j])
    );
  end

  assign match = ~|mismatch;

  // byte count and end-of-scan decisions
  assign seen_base = in_start_of_scan ? '0 : seen_r;
  assign seen_nxt  = (seen_base == SEEN_MAX) ? SEEN_MAX : seen_base + SEEN_W'(1);
  assign pos       = seen_nxt - SEEN_W'(len_u);
  assign pos_p1    = {1'b0, pos} + (SEEN_W+1)'(1);
  assign enough    = seen_nxt >= SEEN_W'(len_u);
  assign past_end  = pos >= SEEN_W'(scan_length_r);
  assign last_pos  = pos_p1 >= (SEEN_W+1)'(scan_length_r);

  always_comb begin
    res_valid = 1'b0;
    res.found = 1'b0;
    res.match_address = '0;
    if (live) begin
      if (scan_length_r == '0) begin
        res_valid = 1'b1;
      end else if (enough) begin
        if (past_end) begin
          res_valid = 1'b1;
        end else if (match) begin
          res_valid = 1'b1;
          res.found = 1'b1;
          res.match_address = base_address_r + pos[ADDR_W-1:0];
        end else if (last_pos) begin
          res_valid = 1'b1;
        end
      end
    end
  end

  always_comb begin
    done_nxt = done_r;
    if (live) done_nxt = res_valid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= '0;
      done_r <= 1'b1;
    end else begin
      done_r <= done_nxt;
      if (live) seen_r <= seen_nxt;
    end
  end

  mbps_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_res   (out_res),
    .full      (buf_full)
  );

  assign out_found         = out_res.found;
  assign out_match_address = out_res.match_address;

  // a scan in progress has always counted its first byte
  a_seen_while_active: assert property (@(posedge clk) disable iff (!rst_n)
    !done_r |-> (seen_r != '0))
    else $error("scan active with zero byte count");

  // a not-found result never carries an address
  a_notfound_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_found) |-> (out_match_address == '0))
    else $error("not-found result with nonzero address");

  // the skid stage fills only behind a held output
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with no result pending");

  // an idle scanner takes bytes without producing results
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && done_r && !in_start_of_scan) |-> !res_valid)
    else $error("result produced while idle");

endmodule

>>> dv/masked_byte_pattern_scanner_tb.sv
// ----------------------------------------------------------------------------
// masked_byte_pattern_scanner_tb: self-checking bench for the signature scanner
// Streams scans of bytes with planted, near-miss and absent patterns under
// several register settings. A scoreboard keeps its own window, byte count and
// register copy, predicts found / not-found per transaction and checks each
// result in order. Random sender bursts and receiver stalls, plus one long
// receiver hold-off that backs the stream up into the input.
// ----------------------------------------------------------------------------
module masked_byte_pattern_scanner_tb;
  import mbps_pkg::*;

  localparam int STUCK_LIMIT = 3000;  // cycles with no transaction anywhere
  localparam int HOLD_CYCLES = 300;   // long receiver hold-off
  localparam int ITEM_GOAL   = 600;

  class scan_scoreboard;
    logic [ADDR_W-1:0]     base_addr;
    logic [31:0]           scan_len;
    logic [PLEN_W-1:0]     pat_len;
    logic [8*PAT_BYTES-1:0] pattern;
    logic [MASK_W-1:0]     care;
    logic [7:0]            window [MAX_PATTERN];
    logic [SEEN_W-1:0]     seen;
    bit                    done;
    scan_result_t          expected_q [$];
    int                    errors;

    function new();
      base_addr = '0;
      scan_len  = '0;
      pat_len   = PLEN_W'(1);
      pattern   = '0;
      care      = '1;
      foreach (window[i]) window[i] = 8'h00;
      seen      = '0;
      done      = 1'b1;
      errors    = 0;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] v);
      case (idx)
        REG_BASE_ADDRESS:   base_addr = v[31:0];
        REG_SCAN_LENGTH:    scan_len  = v[31:0];
        REG_PATTERN_LENGTH: pat_len   = v[PLEN_W-1:0];
        REG_PATTERN_LOW:    pattern[63:0]   = v;
        REG_PATTERN_HIGH:   pattern[127:64] = v;
        REG_CARE_MASK:      care      = v[MASK_W-1:0];
        default: ;
      endcase
    endfunction

    function void finish_scan(logic f, logic [ADDR_W-1:0] a);
      scan_result_t r;
      r.found         = f;
      r.match_address = a;
      expected_q.push_back(r);
      done = 1'b1;
    endfunction

    // returns 1 when the byte is consumed by a scan (not ignored)
    function bit note_byte(logic [7:0] d, logic s);
      int unsigned len;
      logic [SEEN_W-1:0] pos;
      bit hit;
      if (s) begin
        foreach (window[i]) window[i] = 8'h00;
        seen = '0;
        done = 1'b0;
      end
      if (done) return 1'b0;
      for (int i = MAX_PATTERN - 1; i > 0; i--) window[i] = window[i-1];
      window[0] = d;
      if (seen != SEEN_MAX) seen = seen + 1'b1;
      if (scan_len == 0) begin
        finish_scan(1'b0, '0);
        return 1'b1;
      end
      len = (pat_len == 0) ? 1 : (pat_len > MAX_PATTERN) ? MAX_PATTERN : pat_len;
      if (seen < SEEN_W'(len)) return 1'b1;
      pos = seen - SEEN_W'(len);
      // only reachable after a register write in the middle of a scan
      if (pos >= {1'b0, scan_len}) begin
        finish_scan(1'b0, '0);
        return 1'b1;
      end
      hit = 1'b1;
      for (int k = 0; k < len; k++) begin
        if (care[k] && window[len-1-k] != pattern[8*k +: 8]) hit = 1'b0;
      end
      if (hit) finish_scan(1'b1, base_addr + pos[31:0]);
      else if (pos + 1'b1 >= {1'b0, scan_len}) finish_scan(1'b0, '0);
      return 1'b1;
    endfunction

    function void check_result(logic f, logic [ADDR_W-1:0] a);
      scan_result_t exp;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result expected none actual found=%0b addr=%h",
                 $time, f, a);
        return;
      end
      exp = expected_q.pop_front();
      if (f !== exp.found) begin
        errors++;
        $display("%0t: found mismatch expected %0b actual %0b", $time, exp.found, f);
      end
      if (a !== exp.match_address) begin
        errors++;
        $display("%0t: match_address mismatch expected %h actual %h",
                 $time, exp.match_address, a);
      end
    endfunction

    function int outstanding();
      return expected_q.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n             = 1'b0;
  logic                  in_valid          = 1'b0;
  logic                  in_stall;
  logic [7:0]            in_data_byte      = 8'h00;
  logic                  in_start_of_scan  = 1'b0;
  logic                  out_valid;
  logic                  out_stall         = 1'b0;
  logic                  out_found;
  logic [ADDR_W-1:0]     out_match_address;
  logic                  cfg_wr_en         = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index         = '0;
  logic [CFG_DATA_W-1:0] cfg_data          = '0;

  scan_scoreboard sb = new();
  logic [CFG_DATA_W-1:0] reg_vals [6];
  int  burst_left = 0;
  int  consumed   = 0;
  int  stuck      = 0;
  bit  hold_req   = 1'b0;

  masked_byte_pattern_scanner u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_data_byte      (in_data_byte),
    .in_start_of_scan  (in_start_of_scan),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_found         (out_found),
    .out_match_address (out_match_address),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // sender: bursts of random length separated by random gaps
  task automatic send_byte(input logic [7:0] d, input logic s);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid         <= 1'b1;
    in_data_byte     <= d;
    in_start_of_scan <= s;
    do @(posedge clk); while (in_stall);
    if (sb.note_byte(d, s)) consumed++;
  endtask

  // drain all expected results, then allow for a byte still in flight
  task automatic settle();
    in_valid   <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (sb.outstanding() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_regs(input bit [5:0] which);
    for (int i = 0; i < 6; i++) begin
      if (which[i]) begin
        cfg_wr_en <= 1'b1;
        cfg_index <= cfg_reg_t'(i);
        cfg_data  <= reg_vals[i];
        @(posedge clk);
        sb.write_reg(cfg_reg_t'(i), reg_vals[i]);
      end
    end
    cfg_wr_en <= 1'b0;
  endtask

  // receiver stall pattern, with one long hold-off on request
  initial begin
    int mode;
    int span;
    int hold_left;
    bit stall_next;
    mode      = 0;
    span      = 0;
    hold_left = 0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        stall_next = 1'b1;
      end else if (hold_req) begin
        hold_req   = 1'b0;
        hold_left  = HOLD_CYCLES;
        stall_next = 1'b1;
      end else begin
        if (span == 0) begin
          mode = $urandom_range(0, 3);
          span = $urandom_range(20, 200);
        end
        span--;
        case (mode)
          0:       stall_next = 1'b0;
          1:       stall_next = ($urandom_range(0, 1) == 0);
          2:       stall_next = ($urandom_range(0, 9) != 0);
          default: stall_next = ((span % 8) >= 4);
        endcase
      end
      out_stall <= stall_next;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_found, out_match_address);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en) stuck <= 0;
    else stuck <= stuck + 1;
    if (stuck >= STUCK_LIMIT) begin
      $display("masked_byte_pattern_scanner test failed");
      $finish;
    end
  end

  initial begin
    logic [8*PAT_BYTES-1:0] pat;
    logic [7:0] b;
    int phase;
    int nscans;
    int eff;
    int span_lim;
    int n;
    int p;
    bit plant;
    bit cont;
    bit [5:0] which;

    foreach (reg_vals[i]) reg_vals[i] = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: idle byte is ignored, empty scan reports not-found
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    settle();

    // length zero acts as 1; match address wraps past the top of memory
    reg_vals[REG_BASE_ADDRESS]   = 64'hFFFF_FFFF;
    reg_vals[REG_SCAN_LENGTH]    = 64'd2;
    reg_vals[REG_PATTERN_LENGTH] = 64'd0;
    reg_vals[REG_PATTERN_LOW]    = 64'hAB;
    reg_vals[REG_PATTERN_HIGH]   = 64'h0;
    reg_vals[REG_CARE_MASK]      = 64'h0001;
    load_regs(6'b111111);
    send_byte(8'h12, 1'b1);
    send_byte(8'hAB, 1'b0);
    send_byte(8'h34, 1'b0);  // after the result: ignored
    settle();

    // oversize length clamps to 16; pattern runs past a one-position scan
    reg_vals[REG_SCAN_LENGTH]    = 64'd1;
    reg_vals[REG_PATTERN_LENGTH] = 64'd31;
    reg_vals[REG_PATTERN_LOW]    = 64'h5A;
    reg_vals[REG_PATTERN_HIGH]   = 64'hC300_0000_0000_0000;
    reg_vals[REG_CARE_MASK]      = 64'h8001;
    load_regs(6'b111110);
    send_byte(8'h5A, 1'b1);
    for (int i = 0; i < 14; i++) send_byte((i % 2) ? 8'hFF : 8'h00, 1'b0);
    send_byte(8'hC3, 1'b0);
    settle();

    // scan length shrunk in the middle of a scan
    reg_vals[REG_SCAN_LENGTH]    = 64'd3;
    reg_vals[REG_PATTERN_LENGTH] = 64'd1;
    reg_vals[REG_PATTERN_LOW]    = 64'h77;
    reg_vals[REG_CARE_MASK]      = 64'h0001;
    load_regs(6'b101110);
    send_byte(8'h00, 1'b1);
    settle();
    reg_vals[REG_SCAN_LENGTH] = 64'd1;
    load_regs(6'b000010);
    send_byte(8'h77, 1'b0);
    settle();

    phase = 0;
    while (consumed < ITEM_GOAL) begin
      case ($urandom_range(0, 5))
        0:       reg_vals[REG_BASE_ADDRESS] = 64'h0;
        1:       reg_vals[REG_BASE_ADDRESS] = 64'hFFFF_FFFF;
        default: reg_vals[REG_BASE_ADDRESS] = {32'h0, $urandom};
      endcase
      case ($urandom_range(0, 9))
        0:       reg_vals[REG_SCAN_LENGTH] = 64'h0;
        1:       reg_vals[REG_SCAN_LENGTH] = 64'hFFFF_FFFF;
        default: reg_vals[REG_SCAN_LENGTH] = 64'($urandom_range(1, 24));
      endcase
      case ($urandom_range(0, 9))
        0:       reg_vals[REG_PATTERN_LENGTH] = 64'd0;
        1:       reg_vals[REG_PATTERN_LENGTH] = 64'($urandom_range(17, 31));
        2:       reg_vals[REG_PATTERN_LENGTH] = 64'd16;
        default: reg_vals[REG_PATTERN_LENGTH] = 64'($urandom_range(1, 16));
      endcase
      reg_vals[REG_PATTERN_LOW]  = {$urandom, $urandom};
      reg_vals[REG_PATTERN_HIGH] = {$urandom, $urandom};
      case ($urandom_range(0, 4))
        0:       reg_vals[REG_CARE_MASK] = 64'hFFFF;
        1:       reg_vals[REG_CARE_MASK] = 64'h0;
        2:       reg_vals[REG_CARE_MASK] = 64'($urandom_range(0, 65535) & $urandom_range(0, 65535));
        default: reg_vals[REG_CARE_MASK] = 64'($urandom_range(0, 65535));
      endcase
      // first random phase: every scan ends fast, and the receiver holds off
      if (phase == 0) begin
        reg_vals[REG_CARE_MASK]   = 64'h0;
        reg_vals[REG_SCAN_LENGTH] = 64'($urandom_range(1, 4));
      end
      // now and then keep the running scan alive across a partial rewrite
      cont  = (phase != 0) && ($urandom_range(0, 7) == 0);
      which = cont ? 6'($urandom_range(1, 63)) : 6'b111111;
      load_regs(which);
      if (phase == 0) hold_req = 1'b1;

      pat      = {sb.pattern};
      eff      = (sb.pat_len == 0) ? 1 : (sb.pat_len > MAX_PATTERN) ? MAX_PATTERN : sb.pat_len;
      span_lim = (sb.scan_len > 40) ? 40 : int'(sb.scan_len);
      nscans   = (phase == 0) ? 8 : $urandom_range(2, 5);
      for (int sc = 0; sc < nscans; sc++) begin
        n = span_lim + eff + $urandom_range(0, 3);
        if ($urandom_range(0, 5) == 0) n = $urandom_range(1, n);  // cut short
        plant = (span_lim > 0) && ($urandom_range(0, 9) < 6);
        p     = (span_lim > 0) ? $urandom_range(0, span_lim - 1) : 0;
        for (int i = 0; i < n; i++) begin
          case ($urandom_range(0, 3))
            0, 1:    b = 8'($urandom);
            2:       b = pat[8*$urandom_range(0, eff - 1) +: 8];
            default: b = pat[8*(i % eff) +: 8];
          endcase
          if (plant && i >= p && i < p + eff) b = pat[8*(i - p) +: 8];
          send_byte(b, (i == 0) && !(cont && sc == 0));
        end
      end
      settle();
      phase++;
    end

    settle();
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("masked_byte_pattern_scanner test passed");
    end else begin
      $display("masked_byte_pattern_scanner test failed");
    end
    $finish;
  end

endmodule

>>> masked_byte_pattern_scanner.f
hw/rtl/mbps_pkg.sv
hw/rtl/mbps_cell.sv
hw/rtl/mbps_out_buf.sv
hw/rtl/masked_byte_pattern_scanner.sv
dv/masked_byte_pattern_scanner_tb.sv
